// ===== rtl/patt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tree table package
// Mode and status codes and the controller state type.
// ----------------------------------------------------------------------------
package patt_pkg;

	typedef enum logic [3:0] {
		MODE_APPEND     = 4'd0,
		MODE_CLEAR      = 4'd1,
		MODE_DEPTH      = 4'd2,
		MODE_ROOT       = 4'd3,
		MODE_VALUE_AT   = 4'd4,
		MODE_RENAME     = 4'd5,
		MODE_PARENT_OF  = 4'd6,
		MODE_FIRST_CHLD = 4'd7,
		MODE_RIGHT_SIB  = 4'd8,
		MODE_REMOVE     = 4'd9
	} mode_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [7:0] NO_PARENT = 8'hFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_DEPTH,
		S_DEPTH_WALK,
		S_MARK,
		S_DONE
	} state_t;

endpackage : patt_pkg
`default_nettype wire

// ===== rtl/parent_array_tree_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Parent array tree table
// A tree held as a level-ordered row of node cells with parent links.
// ----------------------------------------------------------------------------
// Usage: drive mode and the operand fields with start high; the word is taken
// when busy is low. Exactly one result word follows, shown on status,
// result_char and result_number for one cycle with done high; the receiver
// cannot stall it. Append, clear, value_at and unused modes go only through
// the find and done states before their result shows. Busy drops as the
// result shows, so the next word can be taken in that cycle. Root and key
// searches (rename included) step one cell a cycle. Depth walks the parent
// chain from each node. Remove scans for the child, marks the subtree one cell
// a cycle from that child, then compacts by shifting the row by one cell per
// removed node, renumbering links as they pass.
// The cells are read through two shared indexes; marking and renumbering run
// inside the cells. Reset empties the tree (node count zero); cell contents
// are not cleared.
// ----------------------------------------------------------------------------
module parent_array_tree_table
	import patt_pkg::*;
#(
	parameter int MAX_NODES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [3:0] mode,
	input  wire logic [7:0] node_key,
	input  wire logic [7:0] new_char,
	input  wire logic [6:0] node_index,
	input  wire logic       has_parent,
	input  wire logic [7:0] child_number,
	output logic            done,
	output logic      [1:0] status,
	output logic      [7:0] result_char,
	output logic      [7:0] result_number
);

	localparam int N = MAX_NODES;

	logic [7:0] ch   [N];
	logic [7:0] lk   [N];
	logic       mk   [N];

	state_t     state_q, state_d;
	mode_t      mode_q;
	logic [7:0] key_q, nch_q, cnum_q, cnt_q, i_q, j_q, m_q, d_q, best_q, seen_q;
	logic [7:0] found_q, start_q;
	logic [1:0] st_q;
	logic [7:0] rch_q;
	logic       rm_q;   // remove phase: 0 mark, 1 compact

	// Control to the cells.
	logic       wr_en_c, mark_clr_c, mark_wr_c, mark_val_c, prop_c, shift_c, dec_c;
	logic [7:0] wr_idx_c, wr_char_c, wr_link_c, mark_idx_c, shift_from_c, dec_thr_c;

	// Shared read ports over the row, one at i_q and one at m_q.
	logic [7:0] lk_i, lk_m, ch_i, ch_m;
	logic       mk_i;
	assign lk_i = lk[i_q[$clog2(N)-1:0]];
	assign lk_m = lk[m_q[$clog2(N)-1:0]];
	assign ch_i = ch[i_q[$clog2(N)-1:0]];
	assign ch_m = ch[m_q[$clog2(N)-1:0]];
	assign mk_i = mk[i_q[$clog2(N)-1:0]];

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic [7:0] nbc, nbl;
			logic       nbm;
			if (g < N - 1) begin : g_nb
				assign nbc = ch[g+1];
				assign nbl = lk[g+1];
				assign nbm = mk[g+1];
			end else begin : g_last
				assign nbc = 8'd0;
				assign nbl = NO_PARENT;
				assign nbm = 1'b0;
			end
			patt_cell u_cell (
				.clk        (clk),
				.wr_en      (wr_en_c && wr_idx_c == 8'(g)),
				.wr_char    (wr_char_c),
				.wr_link    (wr_link_c),
				.mark_clr   (mark_clr_c),
				.mark_wr    (mark_wr_c && mark_idx_c == 8'(g)),
				.mark_val   (mark_val_c),
				.prop_en    (prop_c),
				.prop_idx   (i_q),
				.shift_en   (shift_c && 8'(g) >= shift_from_c),
				.nb_char    (nbc),
				.nb_link    (nbl),
				.nb_mark    (nbm),
				.dec_en     (dec_c),
				.dec_thr    (dec_thr_c),
				.node_char_q(ch[g]),
				.link_q     (lk[g]),
				.mark_q     (mk[g])
			);
		end
	endgenerate

	assign busy = (state_q != S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:       if (start) state_d = S_FIND;
			S_DONE:       state_d = S_IDLE;
			S_FIND,
			S_DEPTH,
			S_DEPTH_WALK,
			S_MARK:       state_d = state_q;
			default:      state_d = S_IDLE;
		endcase
	end

	// Cell controls come from the sequencer registers below.
	always_comb begin
		wr_en_c = 1'b0; wr_idx_c = cnt_q; wr_char_c = nch_q; wr_link_c = NO_PARENT;
		mark_clr_c = 1'b0; mark_wr_c = 1'b0; mark_val_c = 1'b0; mark_idx_c = i_q;
		prop_c = 1'b0;
		shift_c = 1'b0; shift_from_c = i_q; dec_c = 1'b0; dec_thr_c = i_q;
		case (state_q)
			S_IDLE: begin
				// Marks are only meaningful during a removal.
				mark_clr_c = 1'b1;
			end
			S_FIND: begin
				if (mode_q == MODE_APPEND && cnt_q < 8'(N) &&
				    !(m_q[0] && d_q >= cnt_q)) begin
					wr_en_c   = 1'b1;
					wr_link_c = m_q[0] ? d_q : NO_PARENT;
				end else if (mode_q == MODE_RENAME && i_q < cnt_q && ch_i == key_q) begin
					wr_en_c   = 1'b1;
					wr_idx_c  = i_q;
					wr_link_c = lk_i;
				end
			end
			S_MARK: begin
				if (!rm_q && i_q < cnt_q) begin
					// The removed child, or any node already marked by its parent,
					// passes its mark to its own children.
					mark_wr_c  = (i_q == start_q);
					mark_val_c = 1'b1;
					prop_c     = (i_q == start_q) || mk_i;
				end else if (rm_q && i_q < cnt_q && mk_i) begin
					shift_c = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 8'd0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_FIND;
						mode_q  <= mode_t'(mode);
						key_q   <= node_key; nch_q <= new_char; cnum_q <= child_number;
						d_q     <= {1'b0, node_index};
						m_q     <= {7'd0, has_parent};
						i_q     <= (mode == MODE_VALUE_AT) ? {1'b0, node_index} : 8'd0;
						j_q <= 8'd0; best_q <= 8'd0; seen_q <= 8'd0;
						found_q <= 8'hFF; st_q <= ST_OK; rch_q <= 8'd0; rm_q <= 1'b0;
					end
				end
				S_FIND: begin
					case (mode_q)
						MODE_APPEND: begin
							if (cnt_q >= 8'(N)) st_q <= ST_FULL;
							else if (m_q[0] && d_q >= cnt_q) st_q <= ST_NOTFOUND;
							else cnt_q <= cnt_q + 8'd1;
							state_q <= S_DONE;
						end
						MODE_CLEAR: begin
							cnt_q <= 8'd0; state_q <= S_DONE;
						end
						MODE_DEPTH, MODE_ROOT, MODE_VALUE_AT, MODE_RENAME, MODE_PARENT_OF,
						MODE_FIRST_CHLD, MODE_RIGHT_SIB, MODE_REMOVE: begin
							if (cnt_q == 8'd0) begin
								st_q <= ST_EMPTY; state_q <= S_DONE;
							end else if (mode_q == MODE_DEPTH) begin
								state_q <= S_DEPTH;
							end else if (mode_q == MODE_VALUE_AT) begin
								if (i_q < cnt_q) rch_q <= ch_i;
								else st_q <= ST_NOTFOUND;
								state_q <= S_DONE;
							end else if (mode_q == MODE_ROOT) begin
								if (i_q >= cnt_q) begin
									st_q <= ST_NOTFOUND; state_q <= S_DONE;
								end else if (lk_i == NO_PARENT) begin
									rch_q <= ch_i; state_q <= S_DONE;
								end else i_q <= i_q + 8'd1;
							end else if (found_q == 8'hFF) begin
								// Key search, one cell a cycle.
								if (i_q >= cnt_q) begin
									st_q <= ST_NOTFOUND; state_q <= S_DONE;
								end else if (ch_i == key_q) begin
									found_q <= i_q;
									case (mode_q)
										MODE_RENAME: state_q <= S_DONE;
										MODE_PARENT_OF: begin
											if (lk_i < cnt_q) m_q <= lk_i;
											else begin
												st_q <= ST_NOTFOUND; state_q <= S_DONE;
											end
										end
										MODE_RIGHT_SIB: m_q <= lk_i;
										default: ;
									endcase
									i_q <= i_q + 8'd1;
								end else i_q <= i_q + 8'd1;
							end else if (mode_q == MODE_PARENT_OF) begin
								// The parent's index now sits in m_q.
								rch_q <= ch_m; state_q <= S_DONE;
							end else if (mode_q == MODE_RIGHT_SIB) begin
								if (m_q != NO_PARENT && i_q < cnt_q && lk_i == m_q)
									rch_q <= ch_i;
								else st_q <= ST_NOTFOUND;
								state_q <= S_DONE;
							end else if (mode_q == MODE_FIRST_CHLD) begin
								if (i_q >= cnt_q) begin
									st_q <= ST_NOTFOUND; state_q <= S_DONE;
								end else if (lk_i == found_q) begin
									rch_q <= ch_i; state_q <= S_DONE;
								end else i_q <= i_q + 8'd1;
							end else begin
								// Remove: find the nth child.
								if (cnum_q == 8'd0 || i_q >= cnt_q) begin
									st_q <= ST_NOTFOUND; state_q <= S_DONE;
								end else if (lk_i == found_q) begin
									if (seen_q + 8'd1 == cnum_q) begin
										start_q <= i_q; state_q <= S_MARK;
									end else begin
										seen_q <= seen_q + 8'd1; i_q <= i_q + 8'd1;
									end
								end else i_q <= i_q + 8'd1;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DEPTH: begin
					if (i_q >= cnt_q) begin
						state_q <= S_DONE;
					end else begin
						m_q <= lk_i; d_q <= 8'd1; j_q <= 8'd0; state_q <= S_DEPTH_WALK;
					end
				end
				S_DEPTH_WALK: begin
					// Climb one link a cycle.
					if (m_q != NO_PARENT && m_q < cnt_q && j_q < cnt_q) begin
						m_q <= lk_m; d_q <= d_q + 8'd1; j_q <= j_q + 8'd1;
					end else begin
						if (d_q > best_q) best_q <= d_q;
						i_q <= i_q + 8'd1; state_q <= S_DEPTH;
					end
				end
				S_MARK: begin
					// Nothing below the removed child is marked, so both passes
					// start there.
					if (!rm_q) begin
						if (i_q + 8'd1 >= cnt_q) begin
							rm_q <= 1'b1; i_q <= start_q;
						end else i_q <= i_q + 8'd1;
					end else if (i_q >= cnt_q) begin
						state_q <= S_DONE;
					end else if (mk_i) begin
						// Cells above shift down one; links above i renumber.
						cnt_q <= cnt_q - 8'd1;
					end else i_q <= i_q + 8'd1;
				end
				S_DONE: begin
					done          <= 1'b1;
					status        <= st_q;
					result_char   <= rch_q;
					result_number <= (mode_q == MODE_DEPTH) ? best_q : cnt_q;
					state_q       <= state_d;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule : parent_array_tree_table
`default_nettype wire

// ===== rtl/patt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tree table cell
// Holds one node: its character, its parent link and a delete mark. On a
// compaction step a cell takes the word of its upper neighbor. A mark is set
// when the index of the cell's parent is broadcast as marked.
// ----------------------------------------------------------------------------
module patt_cell
	import patt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       wr_en,
	input  wire logic [7:0] wr_char,
	input  wire logic [7:0] wr_link,
	input  wire logic       mark_clr,
	input  wire logic       mark_wr,
	input  wire logic       mark_val,
	input  wire logic       prop_en,
	input  wire logic [7:0] prop_idx,
	input  wire logic       shift_en,
	input  wire logic [7:0] nb_char,
	input  wire logic [7:0] nb_link,
	input  wire logic       nb_mark,
	input  wire logic       dec_en,
	input  wire logic [7:0] dec_thr,
	output logic      [7:0] node_char_q,
	output logic      [7:0] link_q,
	output logic            mark_q
);

	// Load, shift from the neighbor, or renumber the link above a removed slot.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			node_char_q <= nb_char;
			link_q      <= (nb_link != NO_PARENT && nb_link > dec_thr) ?
				nb_link - 8'd1 : nb_link;
			mark_q      <= nb_mark;
		end else begin
			if (wr_en) begin
				node_char_q <= wr_char;
				link_q      <= wr_link;
			end else if (dec_en && link_q != NO_PARENT && link_q > dec_thr) begin
				link_q <= link_q - 8'd1;
			end
			// A marked parent passes its mark down to this cell.
			if (mark_clr)
				mark_q <= 1'b0;
			else if (mark_wr)
				mark_q <= mark_val;
			else if (prop_en && link_q == prop_idx)
				mark_q <= 1'b1;
		end
	end

endmodule : patt_cell
`default_nettype wire
